/* hw/rtl/dlbr_pkg.sv */
// Shared types, constants and helpers for the dynamic low band reducer.
// Used by dlbr_mul, dlbr_div and the top level dynamic_low_band_reducer.
package dlbr_pkg;

    // shared multiplier operand and product widths
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 64;

    // activity divider widths
    localparam int NUM_W = 56;
    localparam int DEN_W = 55;
    localparam int Q_W   = 24;
    localparam int CNT_W = $clog2(Q_W);

    // Q0.24 constants (ONE_Q24 is 1.0 in Q1.24)
    localparam logic [23:0] DOM_LOW       = 24'd6375342;
    localparam logic [23:0] DOM_SPAN      = 24'd5704253;
    localparam logic [22:0] MAX_REDUCTION = 23'd7549747;
    localparam logic [24:0] ONE_Q24       = 25'd16777216;
    localparam logic [23:0] HALF_Q24      = 24'd8388608;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_B0         = 3'd0,
        REG_B1         = 3'd1,
        REG_B2         = 3'd2,
        REG_A1         = 3'd3,
        REG_A2         = 3'd4,
        REG_LOW_TIMES  = 3'd5,
        REG_WIDE_TIMES = 3'd6,
        REG_RED_TIMES  = 3'd7
    } t_reg_idx;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BQ,
        ST_BQ_END,
        ST_ENV_M1,
        ST_ENV_M2,
        ST_ENV_FIN,
        ST_ACT_M1,
        ST_ACT_M2,
        ST_ACT_CHK,
        ST_DIV,
        ST_TGT_M,
        ST_TGT_FIN,
        ST_RED,
        ST_OUT
    } t_state;

    // 64-bit signed add that saturates instead of wrapping
    function automatic logic signed [ACC_W-1:0] f_sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            f_sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            f_sat_add = s[ACC_W-1:0];
        end
    endfunction

endpackage

/* hw/rtl/dlbr_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on dlbr_pkg for operand and product widths.
module dlbr_mul
    import dlbr_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // register every product
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

/* hw/rtl/dlbr_div.sv */
// Restoring divider, one quotient bit per cycle, for the activity ratio.
// Depends on dlbr_pkg for widths; caller guarantees numerator below denominator.
module dlbr_div
    import dlbr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quo
);

    logic [NUM_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [Q_W-1:0]   r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [NUM_W:0]   shifted;
    logic [NUM_W:0]   den_ext;
    logic             ge;

    // shift in a zero and trial subtract
    always_comb begin
        shifted = {r_rem[NUM_W-1:0], 1'b0};
        den_ext = {{(NUM_W+1-DEN_W){1'b0}}, r_den};
        ge      = (shifted >= den_ext);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? (shifted - den_ext) : shifted;
            r_quo <= {r_quo[Q_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* hw/rtl/dynamic_low_band_reducer.sv */
// Top level of the dynamic low band reducer: sequencer, state and ports.
// Depends on dlbr_pkg, dlbr_mul and dlbr_div.
//
// One stereo frame is taken per transfer and runs through a sequencer that
// drives one shared 33x33 multiplier and a one-bit-per-cycle divider. A frame
// runs from one input transfer to the next through two biquads, two envelope
// updates, the activity steps, the 24-bit quotient division when the activity
// ratio needs it, the target steps, a third envelope update, output reduction,
// the load of the output register and the idle state that takes the next
// transfer. The sequencer around the shared multiplier sets the frame time,
// and an output stall holds the frame until the output register can load.
// The input is stalled while a frame is in work; a finished frame waits in the
// output register while the next one is taken.
module dynamic_low_band_reducer
    import dlbr_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [2:0]                    i_cfg_addr,
    input  logic [47:0]                   i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_left_in,
    input  logic signed [SAMPLE_BITS-1:0] i_right_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_left_out,
    output logic signed [SAMPLE_BITS-1:0] o_right_out,
    output logic [22:0]                   o_gain_reduction
);

    localparam logic signed [PROD_W-1:0] SMAX =
        (PROD_W'(1) <<< (SAMPLE_BITS - 1)) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] SMIN = -SMAX - PROD_W'(1);

    t_state r_state, n_state;

    logic signed [31:0]            r_coef [5];
    logic [47:0]                   r_times [3];
    logic signed [SAMPLE_BITS-1:0] r_x [2];
    logic signed [31:0]            r_hist [8];
    logic signed [31:0]            r_y [2];
    logic [31:0]                   r_level [3];
    logic [22:0]                   r_target;
    logic [Q_W:0]                  r_act;
    logic signed [ACC_W-1:0]       r_acc;
    logic [DEN_W-1:0]              r_base;
    logic signed [SAMPLE_BITS-1:0] r_res [2];
    logic                          r_ch;
    logic [2:0]                    r_k;
    logic [1:0]                    r_env;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_l, r_out_r;
    logic [22:0]                   r_out_gr;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod64;
    logic [2:0]               km1;
    logic signed [31:0]       coef_sel;
    logic [31:0]              env_old, env_drive;
    logic [47:0]              env_times;
    logic [23:0]              env_c;
    logic [31:0]              mag_yl, mag_yr, mag_l, mag_xl, mag_xr, mag_w;
    logic [NUM_W-1:0]         lhs, num;
    logic [DEN_W-1:0]         den;
    logic                     div_start, div_done;
    logic [Q_W-1:0]           div_quo;
    logic                     in_xfer, out_load;
    logic signed [ACC_W-1:0]  bq_term, bq_round, bq_shift;
    logic signed [31:0]       bq_y;
    logic [ACC_W-1:0]         env_sum;
    logic [47:0]              tgt_sum;
    logic signed [PROD_W-1:0] red_cut, red_diff;
    logic signed [SAMPLE_BITS-1:0] red_out;

    assign in_xfer  = i_in_valid && (r_state == ST_IDLE);
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);
    assign km1      = r_k - 3'd1;
    assign prod64   = prod[ACC_W-1:0];

    // magnitudes of the filter outputs and inputs
    always_comb begin
        mag_yl = r_y[0][31] ? 32'(-r_y[0]) : 32'(r_y[0]);
        mag_yr = r_y[1][31] ? 32'(-r_y[1]) : 32'(r_y[1]);
        mag_l  = (mag_yl > mag_yr) ? mag_yl : mag_yr;
        mag_xl = r_x[0][SAMPLE_BITS-1] ? 32'(-33'(r_x[0])) : 32'(r_x[0]);
        mag_xr = r_x[1][SAMPLE_BITS-1] ? 32'(-33'(r_x[1])) : 32'(r_x[1]);
        mag_w  = (mag_xl > mag_xr) ? mag_xl : mag_xr;
    end

    // pick the envelope being updated
    always_comb begin
        unique case (r_env)
            2'd0: begin
                env_old   = r_level[0];
                env_drive = mag_l;
                env_times = r_times[0];
            end
            2'd1: begin
                env_old   = r_level[1];
                env_drive = mag_w;
                env_times = r_times[1];
            end
            2'd2: begin
                env_old   = r_level[2];
                env_drive = {9'd0, r_target};
                env_times = r_times[2];
            end
            default: begin
                env_old   = '0;
                env_drive = '0;
                env_times = '0;
            end
        endcase
        env_c = (env_drive > env_old) ? env_times[47:24] : env_times[23:0];
    end

    assign coef_sel = (r_k < 3'd5) ? r_coef[r_k] : 32'sd0;

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_BQ: begin
                mul_a = MUL_W'(coef_sel);
                mul_b = (r_k == 3'd0) ? MUL_W'(r_x[r_ch]) : MUL_W'(r_hist[{r_ch, km1[1:0]}]);
            end
            ST_ENV_M1: begin
                mul_a = MUL_W'({1'b0, env_c});
                mul_b = MUL_W'({1'b0, env_old});
            end
            ST_ENV_M2: begin
                mul_a = MUL_W'(ONE_Q24 - {1'b0, env_c});
                mul_b = MUL_W'({1'b0, env_drive});
            end
            ST_ACT_M1: begin
                mul_a = MUL_W'(DOM_LOW);
                mul_b = MUL_W'({1'b0, r_level[1]});
            end
            ST_ACT_M2: begin
                mul_a = MUL_W'(DOM_SPAN);
                mul_b = MUL_W'({1'b0, r_level[1]});
            end
            ST_TGT_M: begin
                mul_a = MUL_W'(MAX_REDUCTION);
                mul_b = MUL_W'(r_act);
            end
            ST_RED: begin
                mul_a = MUL_W'(r_y[r_k[0]]);
                mul_b = MUL_W'({1'b0, r_level[2]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    dlbr_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // activity ratio terms
    always_comb begin
        lhs       = {r_level[0], 24'd0};
        num       = lhs - NUM_W'(r_base);
        den       = prod[DEN_W-1:0];
        div_start = (r_state == ST_ACT_CHK) && (r_level[1] != '0) &&
                    (lhs > NUM_W'(r_base)) && (num < NUM_W'(den));
    end

    dlbr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // arithmetic around the product
    always_comb begin
        bq_term  = (r_k >= 3'd4) ? -prod64 : prod64;
        bq_round = f_sat_add(r_acc, ACC_W'(64'sd1 <<< 29));
        bq_shift = bq_round >>> 30;
        if (bq_shift > 64'sd2147483647) begin
            bq_y = 32'sh7fffffff;
        end else if (bq_shift < -64'sd2147483648) begin
            bq_y = 32'sh80000000;
        end else begin
            bq_y = bq_shift[31:0];
        end
        env_sum  = r_acc + prod64 + ACC_W'(HALF_Q24);
        tgt_sum  = prod[47:0] + 48'(HALF_Q24);
        red_cut  = (prod + $signed(PROD_W'(HALF_Q24))) >>> 24;
        red_diff = PROD_W'(r_x[km1[0]]) - red_cut;
        if (red_diff > SMAX) begin
            red_out = SMAX[SAMPLE_BITS-1:0];
        end else if (red_diff < SMIN) begin
            red_out = SMIN[SAMPLE_BITS-1:0];
        end else begin
            red_out = red_diff[SAMPLE_BITS-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (in_xfer) n_state = ST_BQ;
            ST_BQ:      if (r_k == 3'd5) n_state = ST_BQ_END;
            ST_BQ_END:  n_state = r_ch ? ST_ENV_M1 : ST_BQ;
            ST_ENV_M1:  n_state = ST_ENV_M2;
            ST_ENV_M2:  n_state = ST_ENV_FIN;
            ST_ENV_FIN: begin
                priority case (r_env)
                    2'd0:    n_state = ST_ENV_M1;
                    2'd1:    n_state = ST_ACT_M1;
                    default: n_state = ST_RED;
                endcase
            end
            ST_ACT_M1:  n_state = ST_ACT_M2;
            ST_ACT_M2:  n_state = ST_ACT_CHK;
            ST_ACT_CHK: n_state = div_start ? ST_DIV : ST_TGT_M;
            ST_DIV:     if (div_done) n_state = ST_TGT_M;
            ST_TGT_M:   n_state = ST_TGT_FIN;
            ST_TGT_FIN: n_state = ST_ENV_M1;
            ST_RED:     if (r_k == 3'd2) n_state = ST_OUT;
            ST_OUT:     if (out_load) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // state register and control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ch    <= 1'b0;
            r_k     <= '0;
            r_env   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    r_ch <= 1'b0;
                    r_k  <= '0;
                end
                ST_BQ:     r_k <= (r_k == 3'd5) ? 3'd0 : r_k + 3'd1;
                ST_BQ_END: begin
                    r_ch  <= 1'b1;
                    r_k   <= '0;
                    r_env <= '0;
                end
                ST_ENV_FIN: begin
                    r_env <= r_env + 2'd1;
                    r_k   <= '0;
                end
                ST_TGT_FIN: r_env <= 2'd2;
                ST_RED:     r_k <= r_k + 3'd1;
                default:    r_k <= r_k;
            endcase
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) r_coef[i] <= '0;
            for (int i = 0; i < 3; i++) r_times[i] <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_B0:         r_coef[0]  <= i_cfg_wdata[31:0];
                REG_B1:         r_coef[1]  <= i_cfg_wdata[31:0];
                REG_B2:         r_coef[2]  <= i_cfg_wdata[31:0];
                REG_A1:         r_coef[3]  <= i_cfg_wdata[31:0];
                REG_A2:         r_coef[4]  <= i_cfg_wdata[31:0];
                REG_LOW_TIMES:  r_times[0] <= i_cfg_wdata;
                REG_WIDE_TIMES: r_times[1] <= i_cfg_wdata;
                REG_RED_TIMES:  r_times[2] <= i_cfg_wdata;
                default:        r_times[2] <= r_times[2];
            endcase
        end
    end

    // filter history and levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_hist[i] <= '0;
            for (int i = 0; i < 3; i++) r_level[i] <= '0;
        end else begin
            if (r_state == ST_BQ_END) begin
                r_hist[{r_ch, 2'd1}] <= r_hist[{r_ch, 2'd0}];
                r_hist[{r_ch, 2'd0}] <= 32'(r_x[r_ch]);
                r_hist[{r_ch, 2'd3}] <= r_hist[{r_ch, 2'd2}];
                r_hist[{r_ch, 2'd2}] <= bq_y;
            end
            if (r_state == ST_ENV_FIN && r_env != 2'd3) begin
                r_level[r_env] <= env_sum[55:24];
            end
        end
    end

    // per-frame datapath
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_x[0] <= i_left_in;
            r_x[1] <= i_right_in;
        end
        unique case (r_state)
            ST_BQ:      r_acc <= (r_k == 3'd0) ? '0 : f_sat_add(r_acc, bq_term);
            ST_BQ_END:  r_y[r_ch] <= bq_y;
            ST_ENV_M2:  r_acc <= prod64;
            ST_ACT_M2:  r_base <= prod[DEN_W-1:0];
            ST_ACT_CHK: begin
                if (r_level[1] == '0 || lhs <= NUM_W'(r_base)) begin
                    r_act <= '0;
                end else if (!div_start) begin
                    r_act <= ONE_Q24;
                end
            end
            ST_DIV:     if (div_done) r_act <= {1'b0, div_quo};
            ST_TGT_FIN: r_target <= tgt_sum[46:24];
            ST_RED:     if (r_k != 3'd0) r_res[km1[0]] <= red_out;
            default:    r_acc <= r_acc;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_l  <= r_res[0];
            r_out_r  <= r_res[1];
            r_out_gr <= r_level[2][22:0];
        end
    end

    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_left_out       = r_out_l;
    assign o_right_out      = r_out_r;
    assign o_gain_reduction = r_out_gr;

endmodule
